### rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge once reset is released
`define KRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must never hold once reset is released
`define KRQ_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

### rtl/krq_pkg.sv
// package: shared types, constants and helpers of the keyboard report queue
package krq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_W       = 8;
    localparam int NUM_KEYS    = 6;
    localparam int REPORT_W    = KEY_W * (NUM_KEYS + 1);

    // apb register map
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic REG_RELEASE = 1'b0;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEND   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_REL
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef logic [KEY_W-1:0] t_key;

    // modifiers in the top byte, key a next, key f in the low byte
    function automatic logic [REPORT_W-1:0] pack_report(
        input t_key       mods,
        input logic [2:0] key_count,
        input t_key       ka,
        input t_key       kb,
        input t_key       kc,
        input t_key       kd,
        input t_key       ke,
        input t_key       kf
    );
        // counts of six and seven both keep every key
        pack_report = {mods,
                       (key_count > 3'd0) ? ka : t_key'(0),
                       (key_count > 3'd1) ? kb : t_key'(0),
                       (key_count > 3'd2) ? kc : t_key'(0),
                       (key_count > 3'd3) ? kd : t_key'(0),
                       (key_count > 3'd4) ? ke : t_key'(0),
                       (key_count > 3'd5) ? kf : t_key'(0)};
    endfunction

endpackage

### rtl/krq_mem.sv
// report store: single port synchronous ram with per-entry written flags
module krq_mem #(
    parameter int QUEUE_DEPTH = krq_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  krq_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_addr,
    input  logic [krq_pkg::REPORT_W-1:0] i_wdata,
    output logic [krq_pkg::REPORT_W-1:0] o_rdata
);

    logic [krq_pkg::REPORT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [krq_pkg::REPORT_W-1:0] r_rdata;
    logic [QUEUE_DEPTH-1:0]       r_vld;
    logic                         r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // entries never written read as zero, as after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvld <= r_vld[i_addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

### rtl/krq_ctrl.sv
// queue control: pointers, overwrite count and result sequencer
`include "assert_macros.svh"

module krq_ctrl #(
    parameter int QUEUE_DEPTH = krq_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_kind,
    input  logic                           i_release,
    output logic                           o_busy,
    output krq_pkg::t_mem_ctl              o_mem_ctl,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_mem_addr,
    input  logic [krq_pkg::REPORT_W-1:0]   i_mem_rdata,
    output logic                           o_valid,
    output logic [krq_pkg::REPORT_W-1:0]   o_report,
    output logic                           o_is_report,
    output logic                           o_had_data,
    output logic [7:0]                     o_overwrite_count,
    output logic                           o_last
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

    krq_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW-1:0]   wp_next, rp_next, rp_prev;
    logic [7:0]      r_dropped;
    logic            r_empty, r_rel, r_two;
    logic            accept, ins, snd, empty;

    assign accept = i_start && !o_busy;
    assign ins    = accept && (i_kind == krq_pkg::KIND_INSERT);
    assign snd    = accept && (i_kind == krq_pkg::KIND_SEND);
    assign empty  = (r_wp == r_rp);

    assign wp_next = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
    assign rp_prev = (r_rp == '0) ? LAST_SLOT : r_rp - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= PW'(1);
            r_rp      <= PW'(1);
            r_dropped <= '0;
            r_empty   <= 1'b0;
            r_rel     <= 1'b0;
            r_two     <= 1'b0;
        end else begin
            if (ins) begin
                r_wp <= wp_next;
                // full ring: drop the oldest unsent entry
                if (wp_next == r_rp) begin
                    r_rp      <= rp_next;
                    r_dropped <= r_dropped + 8'd1;
                end
            end
            if (snd) begin
                if (!empty) begin
                    r_rp <= rp_next;
                end
                r_empty <= empty;
                r_rel   <= i_release;
                r_two   <= !empty && i_release;
            end
        end
    end

    // empty send in hold mode reads the entry before the read pointer
    always_comb begin
        o_mem_ctl.wr_en = ins;
        o_mem_ctl.rd_en = snd;
        if (ins) begin
            o_mem_addr = r_wp;
        end else if (empty) begin
            o_mem_addr = rp_prev;
        end else begin
            o_mem_addr = r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the last result cycle of a send can take the next transfer
    assign o_busy = (r_state == krq_pkg::S_DATA) && r_two;

    always_comb begin
        n_state = r_state;
        o_valid = 1'b0;
        case (r_state)
            krq_pkg::S_IDLE: begin
                if (snd) begin
                    n_state = krq_pkg::S_DATA;
                end
            end
            krq_pkg::S_DATA: begin
                o_valid = 1'b1;
                if (r_two) begin
                    n_state = krq_pkg::S_REL;
                end else if (snd) begin
                    n_state = krq_pkg::S_DATA;
                end else begin
                    n_state = krq_pkg::S_IDLE;
                end
            end
            krq_pkg::S_REL: begin
                o_valid = 1'b1;
                n_state = snd ? krq_pkg::S_DATA : krq_pkg::S_IDLE;
            end
            default: begin
                n_state = krq_pkg::S_IDLE;
            end
        endcase
    end

    logic first_res, no_report;
    assign first_res = (r_state == krq_pkg::S_DATA);
    assign no_report = first_res && r_empty && r_rel;

    assign o_report          = (first_res && !no_report) ? i_mem_rdata : '0;
    assign o_is_report       = !no_report;
    assign o_had_data        = !(first_res && r_empty);
    assign o_last            = !(first_res && r_two);
    assign o_overwrite_count = r_dropped;

    `KRQ_ASSERT(a_busy_then_release, i_clk, i_rst_n,
        o_busy |=> (o_valid && r_state == krq_pkg::S_REL), "release result missing")
    `KRQ_ASSERT(a_send_gives_result, i_clk, i_rst_n,
        snd |=> (o_valid && r_state == krq_pkg::S_DATA), "send gave no result")
    `KRQ_ASSERT(a_insert_silent, i_clk, i_rst_n,
        ins |=> !o_valid, "insert produced a result")
    `KRQ_ASSERT(a_slot_stays_empty, i_clk, i_rst_n,
        ins |=> (r_wp != r_rp), "insert left the ring looking empty")
    `KRQ_ASSERT(a_count_on_insert_only, i_clk, i_rst_n,
        !ins |=> $stable(r_dropped), "overwrite count moved without insert")

endmodule

### rtl/keyboard_report_ring_queue.sv
// top level: keyboard report ring queue with apb control register
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  item in   | i_kind, i_modifiers, i_key_count, i_key_* | start high while busy low
//  result    | o_out_*, o_is_report, o_had_data, ...     | o_valid, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
// an insert writes the ram directly; a send reads the ram into a register, then its
// results follow one per cycle (two in release mode when data was queued).
// the next transfer can be taken in the cycle of the last result.
// reset sets pointers to one and clears the overwrite count and ram written flags.
// the receiver cannot stall; busy is high only while a release result waits.
module keyboard_report_ring_queue #(
    parameter int QUEUE_DEPTH = krq_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic [7:0]                 i_modifiers,
    input  logic [2:0]                 i_key_count,
    input  logic [7:0]                 i_key_a,
    input  logic [7:0]                 i_key_b,
    input  logic [7:0]                 i_key_c,
    input  logic [7:0]                 i_key_d,
    input  logic [7:0]                 i_key_e,
    input  logic [7:0]                 i_key_f,
    output logic                       o_valid,
    output logic [7:0]                 o_out_modifiers,
    output logic [7:0]                 o_out_key_a,
    output logic [7:0]                 o_out_key_b,
    output logic [7:0]                 o_out_key_c,
    output logic [7:0]                 o_out_key_d,
    output logic [7:0]                 o_out_key_e,
    output logic [7:0]                 o_out_key_f,
    output logic                       o_is_report,
    output logic                       o_had_data,
    output logic [7:0]                 o_overwrite_count,
    output logic                       o_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [krq_pkg::APB_AW-1:0] paddr,
    input  logic [krq_pkg::APB_DW-1:0] pwdata,
    output logic [krq_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic                         r_release;
    logic                         reg_hit;
    krq_pkg::t_mem_ctl            mem_ctl;
    logic [PW-1:0]                mem_addr;
    logic [krq_pkg::REPORT_W-1:0] in_report, mem_rdata, res_report;

    // apb register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == krq_pkg::REG_RELEASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_release <= pwdata[0];
        end
    end

    assign prdata = reg_hit ? {{(krq_pkg::APB_DW-1){1'b0}}, r_release} : '0;

    assign in_report = krq_pkg::pack_report(i_modifiers, i_key_count, i_key_a, i_key_b,
                                            i_key_c, i_key_d, i_key_e, i_key_f);

    krq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_kind           (i_kind),
        .i_release        (r_release),
        .o_busy           (busy),
        .o_mem_ctl        (mem_ctl),
        .o_mem_addr       (mem_addr),
        .i_mem_rdata      (mem_rdata),
        .o_valid          (o_valid),
        .o_report         (res_report),
        .o_is_report      (o_is_report),
        .o_had_data       (o_had_data),
        .o_overwrite_count(o_overwrite_count),
        .o_last           (o_last)
    );

    krq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(in_report),
        .o_rdata(mem_rdata)
    );

    assign {o_out_modifiers, o_out_key_a, o_out_key_b, o_out_key_c,
            o_out_key_d, o_out_key_e, o_out_key_f} = res_report;

endmodule
